// ===== hdl/gomc_pkg.sv =====
// Shared types and codes of the grid occupancy move checker.
// Depends on nothing; imported by grid_occupancy_move_checker.
package gomc_pkg;

    typedef logic [1:0] t_func;
    localparam t_func FUNC_PLACE = 2'd0;
    localparam t_func FUNC_MOVE  = 2'd1;
    localparam t_func FUNC_QUERY = 2'd2;

    typedef logic [1:0] t_status;
    localparam t_status STATUS_OK      = 2'd0;
    localparam t_status STATUS_TAKEN   = 2'd1;
    localparam t_status STATUS_OUTSIDE = 2'd2;

    typedef logic [1:0] t_quad;
    localparam t_quad QUAD_UL = 2'd0;
    localparam t_quad QUAD_UR = 2'd1;
    localparam t_quad QUAD_LR = 2'd2;
    localparam t_quad QUAD_LL = 2'd3;

    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_AREA_X = 2'd0;
    localparam t_reg_idx REG_AREA_Y = 2'd1;
    localparam t_reg_idx REG_AREA_W = 2'd2;
    localparam t_reg_idx REG_AREA_H = 2'd3;

    localparam int CFG_DW = 16;

    typedef struct packed {
        logic signed [15:0] dst_y;
        logic signed [15:0] dst_x;
        logic signed [15:0] src_y;
        logic signed [15:0] src_x;
    } t_item;

    typedef struct packed {
        logic    pad;
        logic    near_border;
        t_quad   quadrant;
        logic    grew;
        logic    was_taken;
        t_status status;
    } t_result;

endpackage

// ===== hdl/grid_occupancy_move_checker.sv =====
// Grid occupancy move checker: occupancy map in a one-bit synchronous memory,
// window and area registers, and a small sequencer. Depends on gomc_pkg.
//
//   channel  | direction | handshake                | payload
//   s (item) | in        | i_s_tvalid / o_s_tready  | i_s_tdata, i_s_tuser
//   m (item) | out       | o_m_tvalid / i_m_tready  | o_m_tdata
//   cfg      | in        | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// An item is accepted, which issues the memory read, then passes the evaluate and write
// state. A move that frees a source cell inside the grid also passes ST_SRC, the single
// memory write port needing a second slot. After reset a clearing pass writes every
// memory entry, 2**(2*clog2(GRID_DIM)) in all (65536 by default), before any item.
// Results wait in the output register and one hold stage; no new item while the hold
// stage is full.
module grid_occupancy_move_checker #(
    parameter int GRID_DIM = 256,
    parameter int PADDING  = 20,
    parameter int MARGIN   = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    input  gomc_pkg::t_item          i_s_tdata,   // src_x, src_y, dst_x, dst_y
    input  gomc_pkg::t_func          i_s_tuser,   // func
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    output gomc_pkg::t_result        o_m_tdata,   // status, was_taken, grew, quadrant,
                                                  // near_border, zero pad
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  gomc_pkg::t_reg_idx       i_cfg_index,
    input  logic [gomc_pkg::CFG_DW-1:0] i_cfg_data
);
    import gomc_pkg::*;

    localparam int AW     = $clog2(GRID_DIM);
    localparam int MEM_AW = 2 * AW;
    localparam int DEPTH  = 2 ** MEM_AW;
    localparam logic [18:0]        GRID_LIM = 19'(GRID_DIM);
    localparam logic signed [16:0] MIN16    = -17'sd32768;

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_EVAL, ST_SRC} t_state;

    logic mem [DEPTH];
    logic r_rd;

    t_state               r_state;
    logic [MEM_AW-1:0]    r_clr_addr;
    logic signed [15:0]   r_area_x, r_area_y;
    logic [7:0]           r_area_w, r_area_h;
    logic signed [15:0]   r_win_x, r_win_y;
    logic [8:0]           r_win_w, r_win_h;

    t_func                r_func;
    logic                 r_dst_in, r_src_in, r_outside;
    logic [MEM_AW-1:0]    r_dst_addr, r_src_addr;
    t_quad                r_quad;
    logic                 r_near;
    t_result              r_res;
    t_result              r_hold;
    logic                 r_hold_v;
    t_result              r_out;
    logic                 r_out_valid;

    // front end: coordinates of the offered item
    logic signed [17:0] base_x, base_y;
    logic signed [18:0] rx_d, ry_d, rx_s, ry_s;
    logic               dst_in, src_in;
    logic signed [17:0] dx18, dy18, end_x, end_y;
    logic signed [16:0] dx17, dy17, mid_x, mid_y, mid_x_m1, mid_y_m1;
    logic               in_win;
    logic               near;
    t_quad              quad;

    always_comb begin
        base_x = {{2{r_area_x[15]}}, r_area_x} - 18'(MARGIN);
        base_y = {{2{r_area_y[15]}}, r_area_y} - 18'(MARGIN);
        rx_d   = {{3{i_s_tdata.dst_x[15]}}, i_s_tdata.dst_x} - {base_x[17], base_x};
        ry_d   = {{3{i_s_tdata.dst_y[15]}}, i_s_tdata.dst_y} - {base_y[17], base_y};
        rx_s   = {{3{i_s_tdata.src_x[15]}}, i_s_tdata.src_x} - {base_x[17], base_x};
        ry_s   = {{3{i_s_tdata.src_y[15]}}, i_s_tdata.src_y} - {base_y[17], base_y};
        dst_in = !rx_d[18] && !ry_d[18] && (rx_d < GRID_LIM) && (ry_d < GRID_LIM);
        src_in = !rx_s[18] && !ry_s[18] && (rx_s < GRID_LIM) && (ry_s < GRID_LIM);

        dx18  = {{2{i_s_tdata.dst_x[15]}}, i_s_tdata.dst_x};
        dy18  = {{2{i_s_tdata.dst_y[15]}}, i_s_tdata.dst_y};
        end_x = {{2{r_win_x[15]}}, r_win_x} + {9'd0, r_win_w};
        end_y = {{2{r_win_y[15]}}, r_win_y} + {9'd0, r_win_h};
        in_win = (i_s_tdata.dst_x >= r_win_x) && (dx18 < end_x) &&
                 (i_s_tdata.dst_y >= r_win_y) && (dy18 < end_y);

        dx17     = {i_s_tdata.dst_x[15], i_s_tdata.dst_x};
        dy17     = {i_s_tdata.dst_y[15], i_s_tdata.dst_y};
        mid_x    = {r_area_x[15], r_area_x} + {10'd0, r_area_w[7:1]};
        mid_y    = {r_area_y[15], r_area_y} + {10'd0, r_area_h[7:1]};
        mid_x_m1 = mid_x - 17'sd1;
        mid_y_m1 = mid_y - 17'sd1;

        if (dx17 < mid_x) begin
            quad = (dy17 < mid_y) ? QUAD_UL : QUAD_LL;
        end else begin
            quad = (dy17 < mid_y) ? QUAD_UR : QUAD_LR;
        end
        near = ((dx17 == mid_x_m1 || dx17 == mid_x) &&
                i_s_tdata.dst_y >= r_win_y && dy18 < end_y) ||
               ((dy17 == mid_y_m1 || dy17 == mid_y) &&
                i_s_tdata.dst_x >= r_win_x && dx18 < end_x);
    end

    // evaluate stage
    logic               is_place, is_move, move_ok, dst_wr, need_src, grow_ok;
    logic signed [16:0] nx, ny;
    logic [9:0]         nw, nh;
    t_result            res;
    t_result            res_now;
    logic               res_valid;
    logic               accept, out_free;
    logic               mem_we, mem_wdata;
    logic [MEM_AW-1:0]  mem_waddr;

    always_comb begin
        is_place = (r_func == FUNC_PLACE);
        is_move  = (r_func == FUNC_MOVE);
        move_ok  = r_outside || !r_rd;
        dst_wr   = r_dst_in && (is_place || (is_move && move_ok));
        need_src = r_dst_in && is_move && move_ok && r_src_in;

        nx = {r_win_x[15], r_win_x} - 17'(PADDING);
        ny = {r_win_y[15], r_win_y} - 17'(PADDING);
        nw = {1'b0, r_win_w} + 10'(2 * PADDING);
        nh = {1'b0, r_win_h} + 10'(2 * PADDING);
        grow_ok = (nx >= MIN16) && (ny >= MIN16) && !nw[9] && !nh[9];

        res             = '0;
        res.quadrant    = r_quad;
        res.near_border = r_near;
        if (!r_dst_in) begin
            res.status = STATUS_OUTSIDE;
        end else begin
            res.was_taken = r_rd;
            res.grew      = is_move && r_outside && grow_ok;
            res.status    = (is_move && !move_ok) ? STATUS_TAKEN : STATUS_OK;
        end

        res_now   = (r_state == ST_EVAL) ? res : r_res;
        res_valid = (r_state == ST_EVAL && !need_src) || (r_state == ST_SRC);

        mem_we    = 1'b0;
        mem_waddr = r_dst_addr;
        mem_wdata = 1'b1;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = 1'b0;
            end
            ST_EVAL: begin
                mem_we = dst_wr;
            end
            ST_SRC: begin
                mem_we    = 1'b1;
                mem_waddr = r_src_addr;
                mem_wdata = 1'b0;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign o_s_tready  = (r_state == ST_IDLE) && !r_hold_v;
    assign accept      = i_s_tvalid && o_s_tready;
    assign out_free    = !r_out_valid || i_m_tready;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd <= mem[{ry_d[AW-1:0], rx_d[AW-1:0]}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func     <= i_s_tuser;
            r_dst_in   <= dst_in;
            r_src_in   <= src_in;
            r_outside  <= !in_win;
            r_dst_addr <= {ry_d[AW-1:0], rx_d[AW-1:0]};
            r_src_addr <= {ry_s[AW-1:0], rx_s[AW-1:0]};
            r_quad     <= quad;
            r_near     <= near;
        end
        if (r_state == ST_EVAL) begin
            r_res <= res;
        end
        if (!out_free && res_valid) begin
            r_hold <= res_now;
        end
        if (out_free) begin
            r_out <= r_hold_v ? r_hold : res_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_area_x    <= '0;
            r_area_y    <= '0;
            r_area_w    <= 8'd128;
            r_area_h    <= 8'd128;
            r_win_x     <= '0;
            r_win_y     <= '0;
            r_win_w     <= 9'd128;
            r_win_h     <= 9'd128;
            r_hold_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == MEM_AW'(DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    r_state <= need_src ? ST_SRC : ST_IDLE;
                end
                ST_SRC: begin
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            if (i_cfg_valid) begin
                r_win_x <= (i_cfg_index == REG_AREA_X) ? i_cfg_data : r_area_x;
                r_win_y <= (i_cfg_index == REG_AREA_Y) ? i_cfg_data : r_area_y;
                r_win_w <= {1'b0, (i_cfg_index == REG_AREA_W) ? i_cfg_data[7:0] : r_area_w};
                r_win_h <= {1'b0, (i_cfg_index == REG_AREA_H) ? i_cfg_data[7:0] : r_area_h};
                unique case (i_cfg_index)
                    REG_AREA_X: begin
                        r_area_x <= i_cfg_data;
                    end
                    REG_AREA_Y: begin
                        r_area_y <= i_cfg_data;
                    end
                    REG_AREA_W: begin
                        r_area_w <= i_cfg_data[7:0];
                    end
                    REG_AREA_H: begin
                        r_area_h <= i_cfg_data[7:0];
                    end
                    default: begin
                        r_area_x <= r_area_x;
                    end
                endcase
            end else if (r_state == ST_EVAL && is_move && r_dst_in && r_outside && grow_ok) begin
                r_win_x <= nx[15:0];
                r_win_y <= ny[15:0];
                r_win_w <= nw[8:0];
                r_win_h <= nh[8:0];
            end

            if (out_free) begin
                r_out_valid <= r_hold_v || res_valid;
                r_hold_v    <= 1'b0;
            end else if (res_valid) begin
                r_hold_v <= 1'b1;
            end
        end
    end

endmodule
